// File: hdl/bmp_pkg.sv
// Package for the block mean pooling core.
// Holds register codes, field widths and reset values; no dependencies.
package bmp_pkg;

   // Defaults of the core parameters
   localparam int MAX_GRID_WIDTH_DEF = 1024;
   localparam int MAX_POOL_DIM_DEF   = 64;
   localparam int SAMPLE_BITS_DEF    = 16;

   // Configuration register widths
   localparam int GRID_W_BITS    = 11;
   localparam int GRID_H_BITS    = 16;
   localparam int POOL_BITS      = 7;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Output row index width
   localparam int ROW_BITS = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POOL_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POOL_HEIGHT = 2'd3;

   // Register reset values
   localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
   localparam logic [GRID_H_BITS-1:0] GRID_HEIGHT_RST = 16'd1024;
   localparam logic [POOL_BITS-1:0]   POOL_WIDTH_RST  = 7'd8;
   localparam logic [POOL_BITS-1:0]   POOL_HEIGHT_RST = 7'd8;

endpackage

// File: hdl/block_mean_pool_core.sv
// Block mean pooling core: streaming 2-D average pooling over full blocks.
// Depends on bmp_pkg for register codes, widths and reset values.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   req     | in        | req_valid / req_stall | req_sample
//   rsp     | out       | rsp_valid / rsp_stall | rsp_mean, rsp_block_col, rsp_block_row,
//           |           |                       | rsp_frame_done
//   csr     | in        | csr_we                | csr_index, csr_data
//
// A sample that closes no block is accepted with the sum memory read, then added
// and written back. A sample that closes a block also passes through the
// bit-serial divider (one quotient bit a cycle) and a step to load the output
// register, plus any wait while an earlier item is still held in the output
// register. Reset is synchronous and does not clear the sum memory; each block's
// first sample loads its entry.
// req_stall is high whenever the core is not waiting for a sample.
module block_mean_pool_core #(
   parameter int MAX_GRID_WIDTH = bmp_pkg::MAX_GRID_WIDTH_DEF,
   parameter int MAX_POOL_DIM   = bmp_pkg::MAX_POOL_DIM_DEF,
   parameter int SAMPLE_BITS    = bmp_pkg::SAMPLE_BITS_DEF,
   localparam int COL_BITS  = (MAX_GRID_WIDTH > 1) ? $clog2(MAX_GRID_WIDTH) : 1,
   localparam int OFF_BITS  = (MAX_POOL_DIM > 1) ? $clog2(MAX_POOL_DIM) : 1,
   localparam int PD_BITS   = OFF_BITS + 1,
   localparam int AREA_BITS = 2 * OFF_BITS + 1,
   localparam int SUM_BITS  = SAMPLE_BITS + 2 * OFF_BITS,
   localparam int CNT_BITS  = $clog2(SUM_BITS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_mean,
   output logic [COL_BITS-1:0]                rsp_block_col,
   output logic [bmp_pkg::ROW_BITS-1:0]       rsp_block_row,
   output logic                               rsp_frame_done,
   // configuration port
   input  logic                               csr_we,
   input  logic [bmp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bmp_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int GWB = bmp_pkg::GRID_W_BITS;
   localparam int GHB = bmp_pkg::GRID_H_BITS;
   localparam int RWB = bmp_pkg::ROW_BITS;

   // Sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // Configuration registers
   logic [GWB-1:0]               grid_width_ff;
   logic [GHB-1:0]               grid_height_ff;
   logic [bmp_pkg::POOL_BITS-1:0] pool_width_ff;
   logic [bmp_pkg::POOL_BITS-1:0] pool_height_ff;
   logic                         cfg_hit;

   // Frame position
   logic [GWB-1:0]      pos_first_ff, pos_first_in;
   logic [GHB-1:0]      pos_second_ff, pos_second_in;
   logic [OFF_BITS-1:0] off_first_ff, off_first_in;
   logic [OFF_BITS-1:0] off_second_ff, off_second_in;
   logic [COL_BITS-1:0] cur_col_ff, cur_col_in;
   logic [RWB-1:0]      cur_row_ff, cur_row_in;
   logic [GWB-1:0]      col_base_ff, col_base_in;
   logic [GHB-1:0]      row_base_ff, row_base_in;

   // Item in flight
   logic [1:0]                   state_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                         in_block_ff, first_ff, last_ff, frame_last_ff;
   logic [COL_BITS-1:0]          col_ff;
   logic [RWB-1:0]               row_ff;

   // Sum memory
   logic [SUM_BITS-1:0] sum_mem [MAX_GRID_WIDTH];
   logic [SUM_BITS-1:0] rd_data_ff;
   logic signed [SUM_BITS-1:0] sum_new;
   logic [SUM_BITS-1:0] sum_mag;

   // Divider
   logic [SUM_BITS-1:0]  quo_ff;
   logic [AREA_BITS-1:0] rem_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 neg_ff;
   logic [AREA_BITS:0]   shifted;
   logic                 quo_bit;
   logic [SUM_BITS-1:0]  quo_signed;

   // Result register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_ff;
   logic [COL_BITS-1:0]           rsp_col_ff;
   logic [RWB-1:0]                rsp_row_ff;
   logic                          rsp_done_ff;

   // Effective extents and block geometry
   logic [GWB-1:0]       gw_eff;
   logic [GHB-1:0]       gh_eff;
   logic [PD_BITS-1:0]   pw_eff, ph_eff;
   logic [AREA_BITS-1:0] area;
   logic                 fits_col, fits_row, last_col, last_row;
   logic [PD_BITS-1:0]   off_first_inc, off_second_inc;
   logic [GWB:0]         pos_first_inc;
   logic [GHB:0]         pos_second_inc;
   logic                 req_take, out_free;

   // Clamp register values to their legal ranges
   always_comb begin
      if (grid_width_ff == '0) begin
         gw_eff = GWB'(1);
      end else if (32'(grid_width_ff) > 32'(MAX_GRID_WIDTH)) begin
         gw_eff = GWB'(MAX_GRID_WIDTH);
      end else begin
         gw_eff = grid_width_ff;
      end
      gh_eff = (grid_height_ff == '0) ? GHB'(1) : grid_height_ff;
      if (pool_width_ff == '0) begin
         pw_eff = PD_BITS'(1);
      end else if (32'(pool_width_ff) > 32'(MAX_POOL_DIM)) begin
         pw_eff = PD_BITS'(MAX_POOL_DIM);
      end else begin
         pw_eff = PD_BITS'(pool_width_ff);
      end
      if (pool_height_ff == '0) begin
         ph_eff = PD_BITS'(1);
      end else if (32'(pool_height_ff) > 32'(MAX_POOL_DIM)) begin
         ph_eff = PD_BITS'(MAX_POOL_DIM);
      end else begin
         ph_eff = PD_BITS'(pool_height_ff);
      end
   end

   assign area = AREA_BITS'(pw_eff * ph_eff);

   // A block is full when it ends inside the grid; it is the last one when
   // the next block would not fit
   assign fits_col = ((GWB+1)'(col_base_ff) + (GWB+1)'(pw_eff)) <= (GWB+1)'(gw_eff);
   assign last_col = ((GWB+2)'(col_base_ff) + ((GWB+2)'(pw_eff) << 1)) > (GWB+2)'(gw_eff);
   assign fits_row = ((GHB+1)'(row_base_ff) + (GHB+1)'(ph_eff)) <= (GHB+1)'(gh_eff);
   assign last_row = ((GHB+2)'(row_base_ff) + ((GHB+2)'(ph_eff) << 1)) > (GHB+2)'(gh_eff);

   assign off_first_inc  = PD_BITS'(off_first_ff) + PD_BITS'(1);
   assign off_second_inc = PD_BITS'(off_second_ff) + PD_BITS'(1);
   assign pos_first_inc  = (GWB+1)'(pos_first_ff) + (GWB+1)'(1);
   assign pos_second_inc = (GHB+1)'(pos_second_ff) + (GHB+1)'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Advance the grid position past the accepted sample
   always_comb begin
      pos_first_in  = pos_first_ff;
      pos_second_in = pos_second_ff;
      off_first_in  = off_first_ff;
      off_second_in = off_second_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      col_base_in   = col_base_ff;
      row_base_in   = row_base_ff;
      if (pos_first_inc >= (GWB+1)'(gw_eff)) begin
         pos_first_in  = '0;
         off_first_in  = '0;
         cur_col_in    = '0;
         col_base_in   = '0;
         pos_second_in = pos_second_inc[GHB-1:0];
         off_second_in = off_second_inc[OFF_BITS-1:0];
         if (off_second_inc >= ph_eff) begin
            off_second_in = '0;
            cur_row_in    = cur_row_ff + RWB'(1);
            row_base_in   = pos_second_inc[GHB-1:0];
         end
         if (pos_second_inc >= (GHB+1)'(gh_eff)) begin
            pos_second_in = '0;
            off_second_in = '0;
            cur_row_in    = '0;
            row_base_in   = '0;
         end
      end else begin
         pos_first_in = pos_first_inc[GWB-1:0];
         off_first_in = off_first_inc[OFF_BITS-1:0];
         if (off_first_inc >= pw_eff) begin
            off_first_in = '0;
            cur_col_in   = cur_col_ff + COL_BITS'(1);
            col_base_in  = pos_first_inc[GWB-1:0];
         end
      end
   end

   // Hold configuration; any listed register write restarts the frame
   assign cfg_hit = csr_we && ((csr_index == bmp_pkg::REG_GRID_WIDTH)
                            || (csr_index == bmp_pkg::REG_GRID_HEIGHT)
                            || (csr_index == bmp_pkg::REG_POOL_WIDTH)
                            || (csr_index == bmp_pkg::REG_POOL_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= bmp_pkg::GRID_WIDTH_RST;
         grid_height_ff <= bmp_pkg::GRID_HEIGHT_RST;
         pool_width_ff  <= bmp_pkg::POOL_WIDTH_RST;
         pool_height_ff <= bmp_pkg::POOL_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bmp_pkg::REG_GRID_WIDTH:  grid_width_ff  <= csr_data[GWB-1:0];
            bmp_pkg::REG_GRID_HEIGHT: grid_height_ff <= csr_data[GHB-1:0];
            bmp_pkg::REG_POOL_WIDTH:  pool_width_ff  <= csr_data[bmp_pkg::POOL_BITS-1:0];
            bmp_pkg::REG_POOL_HEIGHT: pool_height_ff <= csr_data[bmp_pkg::POOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame position registers
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         pos_first_ff  <= '0;
         pos_second_ff <= '0;
         off_first_ff  <= '0;
         off_second_ff <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         col_base_ff   <= '0;
         row_base_ff   <= '0;
      end else if (req_take) begin
         pos_first_ff  <= pos_first_in;
         pos_second_ff <= pos_second_in;
         off_first_ff  <= off_first_in;
         off_second_ff <= off_second_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         col_base_ff   <= col_base_in;
         row_base_ff   <= row_base_in;
      end
   end

   // Capture the item and its block flags at accept
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff     <= req_sample;
         col_ff        <= cur_col_ff;
         row_ff        <= cur_row_ff;
         in_block_ff   <= fits_col && fits_row;
         first_ff      <= (off_first_ff == '0) && (off_second_ff == '0);
         last_ff       <= (off_first_inc == pw_eff) && (off_second_inc == ph_eff);
         frame_last_ff <= last_col && last_row;
      end
   end

   // Sum memory: read at accept, write back in the cycle after
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_data_ff <= sum_mem[cur_col_ff];
      end
      if (state_ff == ST_SUM && in_block_ff) begin
         sum_mem[col_ff] <= sum_new;
      end
   end

   assign sum_new = first_ff ? SUM_BITS'(sample_ff)
                             : $signed(rd_data_ff) + SUM_BITS'(sample_ff);
   assign sum_mag = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : sum_new;

   // One restoring division step per cycle
   assign shifted    = {rem_ff, quo_ff[SUM_BITS-1]};
   assign quo_bit    = shifted >= (AREA_BITS+1)'(area);
   assign quo_signed = neg_ff ? SUM_BITS'(-quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         quo_ff <= sum_mag;
         rem_ff <= '0;
         cnt_ff <= CNT_BITS'(SUM_BITS - 1);
         neg_ff <= sum_new[SUM_BITS-1];
      end else if (state_ff == ST_DIV) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], quo_bit};
         rem_ff <= quo_bit ? AREA_BITS'(shifted - (AREA_BITS+1)'(area))
                           : shifted[AREA_BITS-1:0];
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_take) state_ff <= ST_SUM;
            ST_SUM:  state_ff <= (in_block_ff && last_ff) ? ST_DIV : ST_IDLE;
            ST_DIV:  if (cnt_ff == '0) state_ff <= ST_OUT;
            ST_OUT:  if (out_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Result register: load when empty or being drained, drop on take
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_mean_ff <= quo_signed[SAMPLE_BITS-1:0];
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= row_ff;
         rsp_done_ff <= frame_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean       = rsp_mean_ff;
   assign rsp_block_col  = rsp_col_ff;
   assign rsp_block_row  = rsp_row_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule
